[rtl/nds_pkg.sv]
// Package of types and constants shared by the nutrient dosing sequencer modules.
`timescale 1ns / 1ps
package nds_pkg;

   localparam int TIME_W = 32;
   localparam int EC_W   = 11;
   localparam int VOL_W  = 12;
   localparam int CONC_W = 16;
   localparam int SPD_W  = 15;
   localparam int DC_W   = 7;
   localparam int VD_W   = VOL_W + DC_W;
   localparam int NUM_W  = 48;
   localparam int DEN_W  = CONC_W + SPD_W;
   localparam int CNT_W  = $clog2(NUM_W);
   localparam int ADDR_W = 5;

   localparam logic [TIME_W-1:0] CALIB_MS  = TIME_W'(60000);
   localparam logic [TIME_W-1:0] GAP_MS    = TIME_W'(500);
   localparam logic [TIME_W-1:0] HOLD_MS   = TIME_W'(600000);
   localparam logic [TIME_W-1:0] WATCH_MS  = TIME_W'(1800000);
   localparam logic [EC_W:0]     RISE_STEP = (EC_W+1)'(7);
   localparam logic [EC_W:0]     BAND_LOW  = (EC_W+1)'(10);
   localparam logic [EC_W:0]     BAND_HIGH = (EC_W+1)'(50);
   localparam logic [DC_W-1:0]   DEFICIT_CAP = DC_W'(100);
   localparam logic [29:0]       DOSE_SCALE  = 30'd600000000;

   localparam logic [TIME_W-1:0] MIX_DELAY_RST  = TIME_W'(1800000);
   localparam logic [TIME_W-1:0] WARN_INTV_RST  = TIME_W'(3600000);
   localparam logic [SPD_W-1:0]  SPEED_RST      = SPD_W'(1000);

   localparam logic [1:0] ACT_EVAL    = 2'd0;
   localparam logic [1:0] ACT_CALIB_A = 2'd1;
   localparam logic [1:0] ACT_CALIB_B = 2'd2;

   localparam logic [2:0] REG_TARGET_EC = 3'd0;
   localparam logic [2:0] REG_VOLUME    = 3'd1;
   localparam logic [2:0] REG_CONC      = 3'd2;
   localparam logic [2:0] REG_SPEED_A   = 3'd3;
   localparam logic [2:0] REG_SPEED_B   = 3'd4;
   localparam logic [2:0] REG_MIX_DELAY = 3'd5;
   localparam logic [2:0] REG_WARN_INTV = 3'd6;
   localparam logic [2:0] REG_DRAIN_EN  = 3'd7;

   typedef struct packed {
      logic [1:0]        action;
      logic [TIME_W-1:0] now_ms;
      logic [EC_W-1:0]   ec;
      logic              reservoir_low;
      logic              draining;
      logic              maintenance;
      logic              drain_pending;
   } req_type;

   typedef struct packed {
      logic pump_a_on;
      logic pump_b_on;
      logic drain_request;
      logic warn_not_rising;
      logic calibrating;
   } rsp_type;

   typedef struct packed {
      logic [EC_W-1:0]   target_ec;
      logic [VOL_W-1:0]  solution_volume;
      logic [CONC_W-1:0] concentration;
      logic [SPD_W-1:0]  speed_a;
      logic [SPD_W-1:0]  speed_b;
      logic [TIME_W-1:0] mix_delay;
      logic [TIME_W-1:0] warn_interval;
      logic              drain_enable;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic eval;
      logic mul_vd;
      logic mul_num;
      logic sel_b;
      logic div_step;
      logic store_a;
      logic store_b;
      logic check;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic dose;
      logic div_last;
   } status_type;

endpackage

[rtl/nds_csr.sv]
// Configuration register bank with its APB-style access port.
`timescale 1ns / 1ps
module nds_csr
   import nds_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] idx;

   assign idx    = paddr[ADDR_W-1:2];
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         case (idx)
            REG_TARGET_EC: cfg_in.target_ec       = pwdata[EC_W-1:0];
            REG_VOLUME:    cfg_in.solution_volume = pwdata[VOL_W-1:0];
            REG_CONC:      cfg_in.concentration   = pwdata[CONC_W-1:0];
            REG_SPEED_A:   cfg_in.speed_a         = pwdata[SPD_W-1:0];
            REG_SPEED_B:   cfg_in.speed_b         = pwdata[SPD_W-1:0];
            REG_MIX_DELAY: cfg_in.mix_delay       = pwdata[TIME_W-1:0];
            REG_WARN_INTV: cfg_in.warn_interval   = pwdata[TIME_W-1:0];
            REG_DRAIN_EN:  cfg_in.drain_enable    = pwdata[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_TARGET_EC: prdata = 32'(cfg_ff.target_ec);
         REG_VOLUME:    prdata = 32'(cfg_ff.solution_volume);
         REG_CONC:      prdata = 32'(cfg_ff.concentration);
         REG_SPEED_A:   prdata = 32'(cfg_ff.speed_a);
         REG_SPEED_B:   prdata = 32'(cfg_ff.speed_b);
         REG_MIX_DELAY: prdata = 32'(cfg_ff.mix_delay);
         REG_WARN_INTV: prdata = 32'(cfg_ff.warn_interval);
         REG_DRAIN_EN:  prdata = 32'(cfg_ff.drain_enable);
         default:       prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_ec       <= '0;
         cfg_ff.solution_volume <= '0;
         cfg_ff.concentration   <= '0;
         cfg_ff.speed_a         <= SPEED_RST;
         cfg_ff.speed_b         <= SPEED_RST;
         cfg_ff.mix_delay       <= MIX_DELAY_RST;
         cfg_ff.warn_interval   <= WARN_INTV_RST;
         cfg_ff.drain_enable    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/nds_datapath.sv]
// Datapath: sequencer state, decision chain, dose multipliers and shared divider.
`timescale 1ns / 1ps
module nds_datapath
   import nds_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type status,
   output rsp_type    rsp_data
);

   req_type           item_ff;
   rsp_type           rsp_ff;
   logic              calib_ff, calib_in, a_ff, a_in, b_ff, b_in;
   logic              want_a_ff, want_a_in, want_b_ff, want_b_in;
   logic              dosed_ff, dosed_in, drain_ff, drain_in, warn_ff, warn_in;
   logic [TIME_W-1:0] run_start_ff, run_start_in, gap_start_ff, gap_start_in;
   logic [TIME_W-1:0] dur_a_ff, dur_b_ff, last_dose_ff, last_dose_in;
   logic [TIME_W-1:0] last_good_ff, last_good_in, last_warn_ff, last_warn_in;
   logic [EC_W-1:0]   ec_before_ff, ec_before_in;
   logic [DC_W-1:0]   dc_ff;
   logic [VD_W-1:0]   vd_ff;
   logic [NUM_W-1:0]  num_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [DEN_W-1:0]  rem_ff;
   logic [CNT_W-1:0]  cnt_ff;

   logic [TIME_W-1:0] now, since_run, since_gap, since_dose, since_good, since_warn;
   logic [EC_W:0]     ec_x, tgt_x;
   logic              invalid, inhibit, good, low_hit, drain_hit, dose_hit;
   logic [EC_W-1:0]   diff;
   logic [DC_W-1:0]   dc_new;
   logic [DEN_W:0]    trial;
   logic              fits;
   logic [TIME_W-1:0] quo_sat;

   assign now        = item_ff.now_ms;
   assign since_run  = now - run_start_ff;
   assign since_gap  = now - gap_start_ff;
   assign since_dose = now - last_dose_ff;
   assign since_good = now - last_good_ff;
   assign since_warn = now - last_warn_ff;
   assign ec_x       = {1'b0, item_ff.ec};
   assign tgt_x      = {1'b0, cfg.target_ec};
   assign invalid    = (item_ff.ec == '0) || (cfg.target_ec == '0) ||
                       (cfg.solution_volume == '0) || (cfg.concentration == '0);
   assign inhibit    = item_ff.reservoir_low | item_ff.draining |
                       item_ff.maintenance | item_ff.drain_pending;
   assign good       = (ec_x + BAND_LOW > tgt_x) && (ec_x < tgt_x + BAND_HIGH);
   assign low_hit    = (item_ff.ec < cfg.target_ec) && (since_good > HOLD_MS) &&
                       (since_dose > cfg.mix_delay);
   assign drain_hit  = cfg.drain_enable && (item_ff.ec > cfg.target_ec) &&
                       (since_good > HOLD_MS);
   assign diff       = cfg.target_ec - item_ff.ec;
   assign dc_new     = (diff > EC_W'(DEFICIT_CAP)) ? DEFICIT_CAP : diff[DC_W-1:0];

   // Priority chain of an evaluation; only one branch may take effect.
   always_comb begin
      calib_in     = calib_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      want_a_in    = want_a_ff;
      want_b_in    = want_b_ff;
      dosed_in     = dosed_ff;
      run_start_in = run_start_ff;
      gap_start_in = gap_start_ff;
      last_dose_in = last_dose_ff;
      last_good_in = last_good_ff;
      last_warn_in = last_warn_ff;
      ec_before_in = ec_before_ff;
      drain_in     = drain_ff;
      warn_in      = warn_ff;
      dose_hit     = 1'b0;
      if (cmd.capture) begin
         drain_in = 1'b0;
         warn_in  = 1'b0;
      end
      if (cmd.eval) begin
         if (item_ff.action == ACT_CALIB_A || item_ff.action == ACT_CALIB_B) begin
            if (!a_ff && !b_ff) begin
               if (item_ff.action == ACT_CALIB_A) a_in = 1'b1;
               else b_in = 1'b1;
               run_start_in = now;
               calib_in     = 1'b1;
            end
         end else if (item_ff.action == ACT_EVAL) begin
            if (calib_ff) begin
               if (since_run > CALIB_MS) begin
                  if (a_ff) a_in = 1'b0;
                  else b_in = 1'b0;
                  calib_in = 1'b0;
               end
            end else if (invalid) begin
               calib_in = calib_ff;
            end else if (inhibit) begin
               a_in         = 1'b0;
               b_in         = 1'b0;
               last_good_in = now;
            end else if (want_b_ff) begin
               b_in         = 1'b1;
               want_b_in    = 1'b0;
               run_start_in = now;
            end else if (b_ff && since_run > dur_b_ff) begin
               b_in         = 1'b0;
               gap_start_in = now;
            end else if (want_a_ff && !b_ff && since_gap > GAP_MS) begin
               a_in         = 1'b1;
               want_a_in    = 1'b0;
               run_start_in = now;
            end else if (a_ff && since_run > dur_a_ff) begin
               a_in         = 1'b0;
               last_dose_in = now;
            end else if (good) begin
               last_good_in = now;
            end else if (low_hit) begin
               dose_hit     = 1'b1;
               want_a_in    = 1'b1;
               want_b_in    = 1'b1;
               last_dose_in = now;
               ec_before_in = item_ff.ec;
               dosed_in     = 1'b1;
            end else if (drain_hit) begin
               drain_in = 1'b1;
            end
         end
      end
      if (cmd.check && item_ff.action == ACT_EVAL && dosed_ff && item_ff.ec != '0) begin
         if (since_dose < WATCH_MS && ec_x > {1'b0, ec_before_ff} + RISE_STEP) begin
            ec_before_in = '0;
         end else if (ec_before_ff != '0 && since_warn > cfg.warn_interval) begin
            warn_in      = 1'b1;
            last_warn_in = now;
         end
      end
   end

   // One restoring division step: the dividend shifts out at the top while
   // quotient bits enter at the bottom of the same register.
   assign trial   = {rem_ff, num_ff[NUM_W-1]};
   assign fits    = trial >= {1'b0, den_ff};
   assign quo_sat = (num_ff[NUM_W-1:TIME_W] != '0) ? '1 : num_ff[TIME_W-1:0];

   assign status.dose     = dose_hit;
   assign status.div_last = (cnt_ff == CNT_W'(NUM_W - 1));
   assign rsp_data        = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         calib_ff     <= 1'b0;
         a_ff         <= 1'b0;
         b_ff         <= 1'b0;
         want_a_ff    <= 1'b0;
         want_b_ff    <= 1'b0;
         dosed_ff     <= 1'b0;
         drain_ff     <= 1'b0;
         warn_ff      <= 1'b0;
         run_start_ff <= '0;
         gap_start_ff <= '0;
         dur_a_ff     <= '0;
         dur_b_ff     <= '0;
         last_good_ff <= '0;
         ec_before_ff <= '0;
         last_dose_ff <= TIME_W'(0) - MIX_DELAY_RST;
         last_warn_ff <= TIME_W'(0) - WARN_INTV_RST;
      end else begin
         calib_ff     <= calib_in;
         a_ff         <= a_in;
         b_ff         <= b_in;
         want_a_ff    <= want_a_in;
         want_b_ff    <= want_b_in;
         dosed_ff     <= dosed_in;
         drain_ff     <= drain_in;
         warn_ff      <= warn_in;
         run_start_ff <= run_start_in;
         gap_start_ff <= gap_start_in;
         last_dose_ff <= last_dose_in;
         last_good_ff <= last_good_in;
         last_warn_ff <= last_warn_in;
         ec_before_ff <= ec_before_in;
         if (cmd.store_a) dur_a_ff <= quo_sat;
         if (cmd.store_b) dur_b_ff <= quo_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) item_ff <= req_data;
      if (dose_hit) dc_ff <= dc_new;
      if (cmd.mul_vd) vd_ff <= VD_W'(cfg.solution_volume) * VD_W'(dc_ff);
      if (cmd.mul_num) begin
         num_ff <= NUM_W'(vd_ff) * NUM_W'(DOSE_SCALE);
         den_ff <= DEN_W'(cfg.concentration) *
                   DEN_W'(cmd.sel_b ? cfg.speed_b : cfg.speed_a);
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         num_ff <= {num_ff[NUM_W-2:0], fits};
         rem_ff <= fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
      if (cmd.emit) begin
         rsp_ff.pump_a_on       <= a_ff;
         rsp_ff.pump_b_on       <= b_ff;
         rsp_ff.drain_request   <= drain_ff;
         rsp_ff.warn_not_rising <= warn_ff;
         rsp_ff.calibrating     <= calib_ff;
      end
   end

endmodule

[rtl/nds_ctrl.sv]
// Controller state machine: sequences evaluation, dose sizing and result hand-off.
`timescale 1ns / 1ps
module nds_ctrl
   import nds_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_EVAL  = 4'd1;
   localparam logic [3:0] S_MULVD = 4'd2;
   localparam logic [3:0] S_MULA  = 4'd3;
   localparam logic [3:0] S_DIVA  = 4'd4;
   localparam logic [3:0] S_MULB  = 4'd5;
   localparam logic [3:0] S_DIVB  = 4'd6;
   localparam logic [3:0] S_CHECK = 4'd7;
   localparam logic [3:0] S_OUT   = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = status.dose ? S_MULVD : S_CHECK;
         end
         S_MULVD: begin
            cmd.mul_vd = 1'b1;
            state_in   = S_MULA;
         end
         S_MULA: begin
            cmd.mul_num = 1'b1;
            state_in    = S_DIVA;
         end
         S_DIVA: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = S_MULB;
         end
         S_MULB: begin
            cmd.store_a = 1'b1;
            cmd.mul_num = 1'b1;
            cmd.sel_b   = 1'b1;
            state_in    = S_DIVB;
         end
         S_DIVB: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.store_b = 1'b1;
            cmd.check   = 1'b1;
            state_in    = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/nutrient_dosing_sequencer.sv]
// Top level of the nutrient dosing sequencer: register bank, controller and datapath.
`timescale 1ns / 1ps
// The sequencer takes one item at a time and returns exactly one result item for each. An
// item that does not size a dose goes through capture, evaluation, the not-rising check and
// the load of the output register, which waits until the previous result is taken. An item
// that sizes a dose also has both pump run times sized by one shared restoring divider that
// resolves one quotient bit per cycle over a 48-bit dividend, pump A first and then pump B,
// each after its numerator multiplication, with a volume-deficit product formed for pump A.
// The output register parts the two sides, so a new item is accepted while the previous
// result still waits to be taken. Configuration is written through the APB-style port
// at byte address four times the register index; pready is always high and reads return
// the stored value. Registers should be written only while the block is idle.
module nutrient_dosing_sequencer
   import nds_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   // Register bank; its outputs are stable during items only if the user writes while idle.
   nds_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The controller owns both handshakes and issues one command set per cycle.
   nds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds every piece of dosing state and the result register.
   nds_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
